/* hdl/csplit_pkg.sv */
// Shared types and constants for the command-line argument splitter.
`timescale 1ns / 1ps
package csplit_pkg;

  localparam int unsigned MAX_BACKSLASH_RUN_DEF = 32767;
  localparam int unsigned MAX_ARGS_DEF = 16383;

  localparam int unsigned CH_W = 16;
  localparam int unsigned REP_W = 15;
  localparam int unsigned IDX_W = 14;
  localparam int unsigned NRES = 3;

  localparam logic [CH_W-1:0] CH_QUOTE = 16'h0022;
  localparam logic [CH_W-1:0] CH_BSLASH = 16'h005C;
  localparam logic [CH_W-1:0] CH_TAB = 16'h0009;
  localparam logic [CH_W-1:0] CH_SPACE = 16'h0020;

  localparam logic KIND_RUN = 1'b0;
  localparam logic KIND_END = 1'b1;

  typedef struct packed {
    logic [CH_W-1:0] ch;
    logic            is_end;
  } in_item_t;

  typedef struct packed {
    logic [CH_W-1:0]  out_char;
    logic [REP_W-1:0] repeat_res;
    logic             kind;
    logic [IDX_W-1:0] arg_index;
    logic             line_end;
  } result_t;

  typedef struct packed {
    logic [CH_W-1:0]  out_char;
    logic [REP_W-1:0] repeat_res;
    logic             kind;
    logic [IDX_W-1:0] arg_index;
    logic             line_end;
    logic             last;
  } out_item_t;

  typedef struct packed {
    logic                 valid;
    logic [1:0]           cnt;
    result_t [NRES-1:0]   res;
  } batch_t;

  function automatic result_t mk_res(logic [CH_W-1:0] c, logic [REP_W-1:0] rep,
                                     logic kind, logic [IDX_W-1:0] idx, logic le);
    result_t r;
    r.out_char = c;
    r.repeat_res = rep;
    r.kind = kind;
    r.arg_index = idx;
    r.line_end = le;
    return r;
  endfunction

endpackage

/* hdl/csplit_if.sv */
// Valid/ready channel carrying one payload per request.
`timescale 1ns / 1ps
interface csplit_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* hdl/command_line_argument_splitter_core.sv */
// Top level of the command-line argument splitter.
// Usage:
//   line: one request per UTF-16 code unit (ch), is_end set on the terminator.
//   args: character runs (kind 0, repeat_res copies of out_char) and
//         end-of-argument marks (kind 1); the result with line_end set carries
//         the argument count in arg_index. last marks the final result of a
//         character request.
// Latency: a character taken into the input register is loaded into the
//   result bank once the bank is free, and its first result is taken from
//   there. Throughput: one character per clock while args is ready and
//   each character gives at most one result; a character giving more
//   results holds the line channel until the single result port has
//   drained them from the bank. A character giving no result does not hold the line channel.
// Reset: clears the input register, the result bank and the splitter state;
//   the next character starts a new line.
// Stall: while args is not ready the result bank holds, the input register
//   fills, then line.ready drops; nothing is lost.
`timescale 1ns / 1ps
module command_line_argument_splitter_core
  import csplit_pkg::*;
#(
  parameter int unsigned MAX_BACKSLASH_RUN = MAX_BACKSLASH_RUN_DEF,
  parameter int unsigned MAX_ARGS = MAX_ARGS_DEF
) (
  input logic clk,
  input logic rst,
  csplit_if.sink   line,
  csplit_if.source args
);

  batch_t batch;
  logic   load_ready;

  csplit_parse #(
    .MAX_BACKSLASH_RUN(MAX_BACKSLASH_RUN),
    .MAX_ARGS(MAX_ARGS)
  ) u_parse (
    .clk(clk),
    .rst(rst),
    .in_valid(line.valid),
    .in_data(line.data),
    .in_ready(line.ready),
    .load_ready(load_ready),
    .batch(batch)
  );

  csplit_outq u_outq (
    .clk(clk),
    .rst(rst),
    .batch(batch),
    .load_ready(load_ready),
    .args(args)
  );

`ifndef SYNTHESIS
  a_line_end_last: assert property (@(posedge clk) disable iff (rst)
    args.valid && args.data.line_end |-> args.data.last && args.data.kind == KIND_END)
    else $error("line end result is not final end mark");

  a_run_nonzero: assert property (@(posedge clk) disable iff (rst)
    args.valid && args.data.kind == KIND_RUN |-> args.data.repeat_res != '0)
    else $error("character run with zero repeat");

  a_end_no_char: assert property (@(posedge clk) disable iff (rst)
    args.valid && args.data.kind == KIND_END |->
      args.data.out_char == '0 && args.data.repeat_res == '0)
    else $error("end mark carries character data");
`endif

endmodule

/* hdl/csplit_parse.sv */
// Input register, splitter state and per-character result logic.
`timescale 1ns / 1ps
module csplit_parse
  import csplit_pkg::*;
#(
  parameter int unsigned MAX_BACKSLASH_RUN = MAX_BACKSLASH_RUN_DEF,
  parameter int unsigned MAX_ARGS = MAX_ARGS_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  in_item_t in_data,
  output logic     in_ready,
  input  logic     load_ready,
  output batch_t   batch
);

  localparam int unsigned BW = $clog2(MAX_BACKSLASH_RUN + 1);
  localparam int unsigned AW = $clog2(MAX_ARGS + 1);

  typedef enum logic [2:0] {
    PH_START,
    PH_EXEQ,
    PH_EXEP,
    PH_GAP,
    PH_ARG
  } phase_t;

  phase_t          phase, phase_next;
  logic [BW-1:0]   backslash_run, backslash_run_next;
  logic [1:0]      quote_count, quote_count_next;
  logic            in_quote_run, in_quote_run_next;
  logic [AW-1:0]   arg_counter, arg_counter_next;
  logic            held_vld;
  in_item_t        held;
  result_t [NRES-1:0] res;
  logic [1:0]      n;

  function automatic logic [IDX_W-1:0] cur_idx(logic [AW-1:0] ac);
    logic [AW-1:0] m;
    m = (ac != '0) ? ac - AW'(1) : '0;
    return IDX_W'(m);
  endfunction

  function automatic logic [AW-1:0] arg_sat(logic [AW-1:0] ac);
    return (ac < AW'(MAX_ARGS)) ? ac + AW'(1) : ac;
  endfunction

  assign in_ready = !held_vld || load_ready;
  assign batch.valid = held_vld;
  assign batch.cnt = n;
  assign batch.res = res;

  always_comb begin
    logic [CH_W-1:0]  c;
    logic             fin, white, quote, bslash, arg_mode, clear;
    logic [BW-1:0]    bs_e, half;
    logic [1:0]       qc_e;
    logic             iqr_e;
    logic [AW-1:0]    ac_e;
    logic [IDX_W-1:0] idx;
    logic [2:0]       qsum;
    c = held.ch;
    fin = held.is_end;
    white = (c == CH_SPACE) || (c == CH_TAB);
    quote = (c == CH_QUOTE);
    bslash = (c == CH_BSLASH);
    arg_mode = 1'b0;
    clear = 1'b0;
    bs_e = backslash_run;
    qc_e = quote_count;
    iqr_e = in_quote_run;
    ac_e = arg_counter;
    half = '0;
    qsum = '0;
    phase_next = phase;
    backslash_run_next = backslash_run;
    quote_count_next = quote_count;
    in_quote_run_next = in_quote_run;
    arg_counter_next = arg_counter;
    res = '0;
    n = 2'd0;
    idx = cur_idx(arg_counter);

    case (phase)
      PH_EXEQ, PH_EXEP: begin
        if (fin) begin
          res[n] = mk_res('0, '0, KIND_END, idx, 1'b0);
          n = n + 2'd1;
          res[n] = mk_res('0, '0, KIND_END, IDX_W'(ac_e), 1'b1);
          n = n + 2'd1;
          clear = 1'b1;
        end else if ((phase == PH_EXEQ && quote) || (phase == PH_EXEP && white)) begin
          res[n] = mk_res('0, '0, KIND_END, idx, 1'b0);
          n = n + 2'd1;
          phase_next = PH_GAP;
        end else begin
          res[n] = mk_res(c, REP_W'(1), KIND_RUN, idx, 1'b0);
          n = n + 2'd1;
        end
      end
      PH_GAP: begin
        if (fin) begin
          res[n] = mk_res('0, '0, KIND_END, IDX_W'(ac_e), 1'b1);
          n = n + 2'd1;
          clear = 1'b1;
        end else if (!white) begin
          ac_e = arg_sat(arg_counter);
          bs_e = '0;
          qc_e = '0;
          iqr_e = 1'b0;
          arg_mode = 1'b1;
        end
      end
      PH_ARG: begin
        arg_mode = 1'b1;
      end
      default: begin
        ac_e = AW'(1);
        arg_counter_next = ac_e;
        idx = '0;
        if (fin) begin
          res[n] = mk_res('0, '0, KIND_END, idx, 1'b0);
          n = n + 2'd1;
          res[n] = mk_res('0, '0, KIND_END, IDX_W'(ac_e), 1'b1);
          n = n + 2'd1;
          clear = 1'b1;
        end else if (quote) begin
          phase_next = PH_EXEQ;
        end else if (white) begin
          res[n] = mk_res('0, '0, KIND_END, idx, 1'b0);
          n = n + 2'd1;
          phase_next = PH_GAP;
        end else begin
          res[n] = mk_res(c, REP_W'(1), KIND_RUN, idx, 1'b0);
          n = n + 2'd1;
          phase_next = PH_EXEP;
        end
      end
    endcase

    if (arg_mode) begin
      idx = cur_idx(ac_e);
      if (iqr_e && (fin || !quote)) begin
        if (qc_e == 2'd2) begin
          qc_e = '0;
        end
        iqr_e = 1'b0;
      end
      phase_next = PH_ARG;
      arg_counter_next = ac_e;
      backslash_run_next = bs_e;
      quote_count_next = qc_e;
      in_quote_run_next = iqr_e;
      if (fin) begin
        if (bs_e != '0) begin
          res[n] = mk_res(CH_BSLASH, REP_W'(bs_e), KIND_RUN, idx, 1'b0);
          n = n + 2'd1;
        end
        res[n] = mk_res('0, '0, KIND_END, idx, 1'b0);
        n = n + 2'd1;
        res[n] = mk_res('0, '0, KIND_END, IDX_W'(ac_e), 1'b1);
        n = n + 2'd1;
        clear = 1'b1;
      end else if (quote) begin
        if (iqr_e) begin
          qsum = {1'b0, qc_e} + 3'd1;
          if (qsum >= 3'd3) begin
            res[n] = mk_res(CH_QUOTE, REP_W'(1), KIND_RUN, idx, 1'b0);
            n = n + 2'd1;
            quote_count_next = '0;
          end else begin
            quote_count_next = qsum[1:0];
          end
        end else begin
          half = bs_e >> 1;
          if (half != '0) begin
            res[n] = mk_res(CH_BSLASH, REP_W'(half), KIND_RUN, idx, 1'b0);
            n = n + 2'd1;
          end
          if (!bs_e[0]) begin
            quote_count_next = qc_e + 2'd1;
          end else begin
            res[n] = mk_res(CH_QUOTE, REP_W'(1), KIND_RUN, idx, 1'b0);
            n = n + 2'd1;
          end
          backslash_run_next = '0;
          in_quote_run_next = 1'b1;
        end
      end else if (bslash) begin
        if (bs_e < BW'(MAX_BACKSLASH_RUN)) begin
          backslash_run_next = bs_e + BW'(1);
        end
      end else begin
        if (bs_e != '0) begin
          res[n] = mk_res(CH_BSLASH, REP_W'(bs_e), KIND_RUN, idx, 1'b0);
          n = n + 2'd1;
        end
        backslash_run_next = '0;
        if (white && qc_e == 2'd0) begin
          res[n] = mk_res('0, '0, KIND_END, idx, 1'b0);
          n = n + 2'd1;
          phase_next = PH_GAP;
        end else begin
          res[n] = mk_res(c, REP_W'(1), KIND_RUN, idx, 1'b0);
          n = n + 2'd1;
        end
      end
    end

    if (clear) begin
      phase_next = PH_START;
      backslash_run_next = '0;
      quote_count_next = '0;
      in_quote_run_next = 1'b0;
      arg_counter_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_vld <= 1'b0;
      phase <= PH_START;
      backslash_run <= '0;
      quote_count <= '0;
      in_quote_run <= 1'b0;
      arg_counter <= '0;
    end else begin
      if (in_valid && in_ready) begin
        held_vld <= 1'b1;
      end else if (load_ready) begin
        held_vld <= 1'b0;
      end
      if (held_vld && load_ready) begin
        phase <= phase_next;
        backslash_run <= backslash_run_next;
        quote_count <= quote_count_next;
        in_quote_run <= in_quote_run_next;
        arg_counter <= arg_counter_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held <= in_data;
    end
  end

endmodule

/* hdl/csplit_outq.sv */
// Result register bank that hands out up to three results one per request.
`timescale 1ns / 1ps
module csplit_outq
  import csplit_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  batch_t batch,
  output logic   load_ready,
  csplit_if.source args
);

  result_t [NRES-1:0] q;
  logic [1:0] cnt;
  logic [1:0] ptr;
  logic       at_last;
  logic       drain;
  result_t    cur;

  assign cur = q[ptr];
  assign at_last = (ptr == cnt - 2'd1);
  assign drain = args.valid && args.ready;
  assign load_ready = (cnt == 2'd0) || (drain && at_last);

  assign args.valid = (cnt != 2'd0);
  assign args.data.out_char = cur.out_char;
  assign args.data.repeat_res = cur.repeat_res;
  assign args.data.kind = cur.kind;
  assign args.data.arg_index = cur.arg_index;
  assign args.data.line_end = cur.line_end;
  assign args.data.last = at_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      ptr <= '0;
    end else if (batch.valid && load_ready) begin
      cnt <= batch.cnt;
      ptr <= '0;
    end else if (drain) begin
      if (at_last) begin
        cnt <= '0;
        ptr <= '0;
      end else begin
        ptr <= ptr + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (batch.valid && load_ready) begin
      q <= batch.res;
    end
  end

endmodule

/* tb/tb_command_line_argument_splitter_core.sv */
// Self-checking bench for the command-line argument splitter core.
`timescale 1ns / 1ps
module tb_command_line_argument_splitter_core;
  import csplit_pkg::*;

  localparam int unsigned BS_LIMIT = MAX_BACKSLASH_RUN_DEF;
  localparam int unsigned ARG_LIMIT = MAX_ARGS_DEF;
  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned RANDOM_ITEMS = 270;
  localparam int unsigned MAX_REPORTS = 100;

  typedef enum logic [2:0] {
    PH_START, PH_EXEQ, PH_EXEP, PH_GAP, PH_ARG
  } split_phase_t;

  class split_scoreboard;
    out_item_t expected_results[$];
    out_item_t batch[$];
    int unsigned errors;
    int unsigned bs_max;
    int unsigned args_max;
    split_phase_t phase;
    int unsigned bs_run;
    int unsigned quote_state;
    bit in_quote_run;
    int unsigned arg_count;

    function new(int unsigned bs_lim, int unsigned arg_lim);
      bs_max = bs_lim;
      args_max = arg_lim;
      errors = 0;
      clear_line();
    endfunction

    function void clear_line();
      phase = PH_START;
      bs_run = 0;
      quote_state = 0;
      in_quote_run = 1'b0;
      arg_count = 0;
    endfunction

    function logic [IDX_W-1:0] cur_idx();
      return (arg_count != 0) ? IDX_W'(arg_count - 1) : '0;
    endfunction

    function void open_arg();
      if (arg_count < args_max) arg_count++;
    endfunction

    function void emit(logic [CH_W-1:0] c, logic [REP_W-1:0] rep, logic kind,
                       logic [IDX_W-1:0] idx, logic le);
      out_item_t r;
      r.out_char = c;
      r.repeat_res = rep;
      r.kind = kind;
      r.arg_index = idx;
      r.line_end = le;
      r.last = 1'b0;
      batch.push_back(r);
    endfunction

    function void close_line();
      emit('0, '0, KIND_END, IDX_W'(arg_count), 1'b1);
      clear_line();
    endfunction

    function void flush_bs(int unsigned count);
      if (count != 0) emit(CH_BSLASH, REP_W'(count), KIND_RUN, cur_idx(), 1'b0);
    endfunction

    function void note_char(in_item_t it);
      logic [CH_W-1:0] c;
      bit e;
      bit white;
      bit in_arg;
      c = it.ch;
      e = it.is_end;
      white = (c == CH_SPACE) || (c == CH_TAB);
      in_arg = 1'b0;
      batch.delete();
      case (phase)
        PH_START: begin
          arg_count = 0;
          open_arg();
          if (e) begin
            emit('0, '0, KIND_END, cur_idx(), 1'b0);
            close_line();
          end else if (c == CH_QUOTE) begin
            phase = PH_EXEQ;
          end else if (white) begin
            emit('0, '0, KIND_END, cur_idx(), 1'b0);
            phase = PH_GAP;
          end else begin
            emit(c, REP_W'(1), KIND_RUN, cur_idx(), 1'b0);
            phase = PH_EXEP;
          end
        end
        PH_EXEQ, PH_EXEP: begin
          if (e) begin
            emit('0, '0, KIND_END, cur_idx(), 1'b0);
            close_line();
          end else if ((phase == PH_EXEQ && c == CH_QUOTE) ||
                       (phase == PH_EXEP && white)) begin
            emit('0, '0, KIND_END, cur_idx(), 1'b0);
            phase = PH_GAP;
          end else begin
            emit(c, REP_W'(1), KIND_RUN, cur_idx(), 1'b0);
          end
        end
        PH_GAP: begin
          if (e) begin
            close_line();
          end else if (!white) begin
            open_arg();
            phase = PH_ARG;
            bs_run = 0;
            quote_state = 0;
            in_quote_run = 1'b0;
            in_arg = 1'b1;
          end
        end
        default: in_arg = 1'b1;
      endcase
      if (in_arg) begin
        if (in_quote_run && !(!e && c == CH_QUOTE)) begin
          if (quote_state == 2) quote_state = 0;
          in_quote_run = 1'b0;
        end
        if (e) begin
          flush_bs(bs_run);
          emit('0, '0, KIND_END, cur_idx(), 1'b0);
          close_line();
        end else if (c == CH_QUOTE) begin
          if (in_quote_run) begin
            quote_state++;
            if (quote_state >= 3) begin
              emit(CH_QUOTE, REP_W'(1), KIND_RUN, cur_idx(), 1'b0);
              quote_state = 0;
            end
          end else begin
            flush_bs(bs_run >> 1);
            if (bs_run[0] == 1'b0) quote_state++;
            else emit(CH_QUOTE, REP_W'(1), KIND_RUN, cur_idx(), 1'b0);
            bs_run = 0;
            in_quote_run = 1'b1;
          end
        end else if (c == CH_BSLASH) begin
          if (bs_run < bs_max) bs_run++;
        end else if (white && quote_state == 0) begin
          flush_bs(bs_run);
          bs_run = 0;
          emit('0, '0, KIND_END, cur_idx(), 1'b0);
          phase = PH_GAP;
        end else begin
          flush_bs(bs_run);
          bs_run = 0;
          emit(c, REP_W'(1), KIND_RUN, cur_idx(), 1'b0);
        end
      end
      if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
      foreach (batch[i]) expected_results.push_back(batch[i]);
    endfunction

    function void compare(string field, logic [CH_W-1:0] want, logic [CH_W-1:0] got);
      if (want !== got) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_results.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: result with none expected, expected nothing actual %p",
                   $time, got);
        return;
      end
      want = expected_results.pop_front();
      compare("out_char", want.out_char, got.out_char);
      compare("repeat_res", CH_W'(want.repeat_res), CH_W'(got.repeat_res));
      compare("kind", CH_W'(want.kind), CH_W'(got.kind));
      compare("arg_index", CH_W'(want.arg_index), CH_W'(got.arg_index));
      compare("line_end", CH_W'(want.line_end), CH_W'(got.line_end));
      compare("last", CH_W'(want.last), CH_W'(got.last));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic no_idle = 1'b0;
  int unsigned cycle_count = 0;
  int unsigned quiet_cycles = 0;
  split_scoreboard sb;

  csplit_if #(.payload_t(in_item_t)) line_ch ();
  csplit_if #(.payload_t(out_item_t)) args_ch ();

  command_line_argument_splitter_core #(
    .MAX_BACKSLASH_RUN(BS_LIMIT),
    .MAX_ARGS(ARG_LIMIT)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .line(line_ch),
    .args(args_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    no_idle <= ((cycle_count % 1024) >= 700);
    args_ch.ready <= no_idle || ($urandom_range(0, 99) >= 36);
  end

  always @(posedge clk) begin
    if (!rst && args_ch.valid && args_ch.ready) sb.check_result(args_ch.data);
  end

  always @(posedge clk) begin
    if ((line_ch.valid && line_ch.ready) || (args_ch.valid && args_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic send_char(input logic [CH_W-1:0] c, input logic e);
    in_item_t it;
    it.ch = c;
    it.is_end = e;
    if (!no_idle && $urandom_range(0, 99) < 36) begin
      line_ch.valid <= 1'b0;
      do @(posedge clk); while (!no_idle && $urandom_range(0, 99) < 36);
    end
    line_ch.valid <= 1'b1;
    line_ch.data <= it;
    do @(posedge clk); while (!line_ch.ready);
    sb.note_char(it);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char({8'h00, s[i]}, 1'b0);
  endtask

  initial begin
    int unsigned sent;
    int unsigned len;
    int unsigned pick;
    logic [CH_W-1:0] c;
    sb = new(BS_LIMIT, ARG_LIMIT);
    line_ch.valid = 1'b0;
    line_ch.data = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // empty line, then empty executable followed by one argument
    send_char(16'hFFFF, 1'b1);
    send_text(" x");
    send_char(16'h0000, 1'b1);
    // quoted path, backslashes before quotes, triple quote, trailing backslashes
    send_text("\"a\"\tb\\\\\"c\\\\\\\"\"\"\" d\\\\");
    send_char(16'h1234, 1'b1);
    // plain path with literal quote and backslash, extreme code units
    send_text("e\"\\");
    send_char(16'hFFFF, 1'b0);
    send_char(CH_TAB, 1'b0);
    send_char(16'h0000, 1'b0);
    send_char(CH_SPACE, 1'b0);
    send_char(16'h0000, 1'b1);

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      len = $urandom_range(0, 16);
      repeat (len) begin
        pick = $urandom_range(0, 99);
        if (pick < 15) c = CH_QUOTE;
        else if (pick < 30) c = CH_BSLASH;
        else if (pick < 42) c = CH_SPACE;
        else if (pick < 48) c = CH_TAB;
        else if (pick < 90) c = CH_W'(8'h61 + $urandom_range(0, 25));
        else c = CH_W'($urandom);
        send_char(c, 1'b0);
        sent++;
      end
      c = ($urandom_range(0, 99) < 70) ? '0 : CH_W'($urandom);
      send_char(c, 1'b1);
      sent++;
    end

    send_text("q \"r s\"");
    send_char(16'h0000, 1'b1);
    line_ch.valid <= 1'b0;

    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.expected_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/csplit_pkg.sv
hdl/csplit_if.sv
hdl/csplit_parse.sv
hdl/csplit_outq.sv
hdl/command_line_argument_splitter_core.sv
tb/tb_command_line_argument_splitter_core.sv
